### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define CRC8PF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("crc8pf assertion failed");

// next-cycle implication, off while reset is held
`define CRC8PF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("crc8pf assertion failed");

`endif

### src/crc8pf_pkg.sv
// ----------------------------------------------------------------------------
// crc8pf_pkg
// Types, constants and the CRC-8 byte update for the packet framer.
// ----------------------------------------------------------------------------
package crc8pf_pkg;

  localparam logic [7:0] CRC_POLY       = 8'h8C;  // reflected Maxim polynomial
  localparam logic [7:0] CRC_INIT       = 8'h00;
  localparam logic [7:0] START_CODE_RST = 8'd10;

  // function codes of an input word
  localparam logic FUNC_HEADER  = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  // register map
  localparam int         ADDR_W         = 3;
  localparam logic       REG_START_CODE = 1'b0;  // word index, paddr[2]

  // up to four output words produced by one input word
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            frame_end;
    logic            err;
  } bundle_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] v;
    c = crc;
    v = b;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ v[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      v = v >> 1;
    end
    return c;
  endfunction

endpackage

### src/crc8_packet_framer_unit.sv
// Packet framer: start code, type, length, payload, CRC-8 (Maxim, reflected).
// The input word is first taken into the input register, then passed to the
// output register once that is free; the first output word comes from there.
// Throughput: one input word per cycle while each gives a single output word
// and out_stall is low; a header gives 3 or 4 words, a closing payload byte 2.
// Reset (rst_n low, synchronous): no packet open, CRC 0, start code 10.
module crc8_packet_framer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [crc8pf_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [7:0]                      in_pkt_type,
  input  logic [7:0]                      in_pkt_length,
  input  logic [7:0]                      in_data_byte,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_frame_end,
  output logic                            out_run_last,
  output logic                            out_framing_error
);
  import crc8pf_pkg::*;

  // configuration
  logic [7:0] start_code_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_START_CODE) ? {24'd0, start_code_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
    end else if (cfg_wr && paddr[2] == REG_START_CODE) begin
      start_code_r <= pwdata[7:0];
    end
  end

  // input register
  logic       in_vld_r;
  logic       func_r;
  logic [7:0] type_r;
  logic [7:0] len_r;
  logic [7:0] data_r;
  logic [7:0] crc_type_r;   // CRC over the type byte, taken early
  logic       accept;
  logic       advance;
  logic       q_free;

  assign advance  = in_vld_r && q_free;
  assign in_stall = in_vld_r && !q_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_func;
      type_r     <= in_pkt_type;
      len_r      <= in_pkt_length;
      data_r     <= in_data_byte;
      crc_type_r <= crc8_byte(CRC_INIT, in_pkt_type);
    end
  end

  // framing state
  logic       open_r, open_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] rem_dec;
  logic [7:0] crc_hdr;
  logic [7:0] crc_pay;
  bundle_t    bnd;

  assign crc_hdr = crc8_byte(crc_type_r, len_r);
  assign crc_pay = crc8_byte(crc_r, data_r);
  assign rem_dec = rem_r - 8'd1;

  always_comb begin
    open_nxt       = open_r;
    rem_nxt        = rem_r;
    crc_nxt        = crc_r;
    bnd.bytes      = '0;
    bnd.last_idx   = 2'd0;
    bnd.frame_end  = 1'b0;
    bnd.err        = 1'b0;
    if (func_r == FUNC_HEADER) begin
      // a header always restarts, dropping any open packet
      crc_nxt      = crc_hdr;
      bnd.bytes    = {crc_hdr, len_r, type_r, start_code_r};
      if (len_r == 8'd0) begin
        bnd.last_idx  = 2'd3;
        bnd.frame_end = 1'b1;
        open_nxt      = 1'b0;
        rem_nxt       = 8'd0;
      end else begin
        bnd.last_idx  = 2'd2;
        open_nxt      = 1'b1;
        rem_nxt       = len_r;
      end
    end else if (!open_r) begin
      bnd.err = 1'b1;
    end else begin
      crc_nxt      = crc_pay;
      rem_nxt      = rem_dec;
      bnd.bytes[0] = data_r;
      bnd.bytes[1] = crc_pay;
      if (rem_dec == 8'd0) begin
        bnd.last_idx  = 2'd1;
        bnd.frame_end = 1'b1;
        open_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rem_r  <= 8'd0;
      crc_r  <= CRC_INIT;
    end else if (advance) begin
      open_r <= open_nxt;
      rem_r  <= rem_nxt;
      crc_r  <= crc_nxt;
    end
  end

  crc8pf_outq u_outq (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (advance),
    .bundle            (bnd),
    .free              (q_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_byte       (out_tx_byte),
    .out_frame_end     (out_frame_end),
    .out_run_last      (out_run_last),
    .out_framing_error (out_framing_error)
  );

endmodule

### src/crc8pf_outq.sv
// ----------------------------------------------------------------------------
// crc8pf_outq
// Holds the words of one input item and hands them out one per handshake.
// ----------------------------------------------------------------------------
module crc8pf_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  crc8pf_pkg::bundle_t  bundle,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_tx_byte,
  output logic                 out_frame_end,
  output logic                 out_run_last,
  output logic                 out_framing_error
);
  import crc8pf_pkg::*;

  bundle_t    bnd_r;
  logic       vld_r;
  logic [1:0] idx_r;
  logic       last;

  assign last  = (idx_r == bnd_r.last_idx);
  // free when empty or the final word leaves this cycle
  assign free  = !vld_r || (!out_stall && last);

  assign out_valid         = vld_r;
  assign out_tx_byte       = bnd_r.bytes[idx_r];
  assign out_run_last      = last;
  assign out_frame_end     = bnd_r.frame_end && last;
  assign out_framing_error = bnd_r.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (free) begin
      vld_r <= load;
      idx_r <= 2'd0;
    end else if (!out_stall) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      bnd_r <= bundle;
    end
  end

endmodule

### src/crc8pf_checker.sv
// ----------------------------------------------------------------------------
// crc8pf_checker
// Port-level checks on the framer's output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc8pf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_tx_byte,
  input logic       out_frame_end,
  input logic       out_run_last,
  input logic       out_framing_error
);

  // stalled word holds
  `CRC8PF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_tx_byte) && $stable(out_run_last))

  // CRC word always closes its run
  `CRC8PF_ASSERT_NOW(a_end_last, clk, rst_n, out_valid && out_frame_end, out_run_last)

  // error word is a lone zero word
  `CRC8PF_ASSERT_NOW(a_err_word, clk, rst_n, out_valid && out_framing_error, out_run_last && !out_frame_end && out_tx_byte == 8'd0)

  // words of one run come without a gap
  `CRC8PF_ASSERT_NEXT(a_run_cont, clk, rst_n, out_valid && !out_stall && !out_run_last, out_valid)

endmodule

bind crc8_packet_framer_unit crc8pf_checker u_crc8pf_checker (.*);

### sim/crc8_packet_framer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_packet_framer_unit_test
// Self-checking bench for the CRC-8 packet framer. Header and payload words
// go in as directed cases, then as random packets (some abandoned, some stray
// payload) under random sender gaps and receiver stalls. Each output word is
// checked against a tracked copy of the framer state and the start code.
// ----------------------------------------------------------------------------
module crc8_packet_framer_unit_test;
  import crc8pf_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTS    = 60;
  localparam logic [ADDR_W-1:0] START_CODE_ADDR = {REG_START_CODE, 2'b00};

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       run_last;
    logic       framing_error;
  } framed_word_t;

  // tracks the open packet and the bytes the framer must emit
  class frame_tracker_t;
    logic [7:0]   start_code;
    bit           pkt_open;
    logic [7:0]   bytes_left;
    logic [7:0]   crc;
    framed_word_t pending_tx[$];
    int           failures;
    int           printed;

    function new();
      start_code = START_CODE_RST;
      pkt_open   = 0;
      bytes_left = 8'd0;
      crc        = CRC_INIT;
      failures   = 0;
      printed    = 0;
    endfunction

    // reflected CRC-8, LSB first
    function logic [7:0] crc_update(logic [7:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function void push(logic [7:0] b, logic fe, logic last, logic err);
      framed_word_t w;
      w.tx_byte       = b;
      w.frame_end     = fe;
      w.run_last      = last;
      w.framing_error = err;
      pending_tx.push_back(w);
    endfunction

    function void note_word(logic func, logic [7:0] ty, logic [7:0] len,
                            logic [7:0] data);
      if (func == FUNC_HEADER) begin
        crc = crc_update(crc_update(CRC_INIT, ty), len);
        push(start_code, 1'b0, 1'b0, 1'b0);
        push(ty, 1'b0, 1'b0, 1'b0);
        if (len == 8'd0) begin
          push(len, 1'b0, 1'b0, 1'b0);
          push(crc, 1'b1, 1'b1, 1'b0);
          pkt_open   = 0;
          bytes_left = 8'd0;
        end else begin
          push(len, 1'b0, 1'b1, 1'b0);
          pkt_open   = 1;
          bytes_left = len;
        end
      end else if (!pkt_open) begin
        push(8'h00, 1'b0, 1'b1, 1'b1);
      end else begin
        crc        = crc_update(crc, data);
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) begin
          push(data, 1'b0, 1'b0, 1'b0);
          push(crc, 1'b1, 1'b1, 1'b0);
          pkt_open = 0;
        end else begin
          push(data, 1'b0, 1'b1, 1'b0);
        end
      end
    endfunction

    task report(string msg);
      failures++;
      if (printed < MAX_PRINTS) begin
        printed++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
    endtask

    task check_tx(framed_word_t got);
      framed_word_t want;
      if (pending_tx.size() == 0) begin
        report($sformatf("unexpected word tx_byte=%02h", got.tx_byte));
        return;
      end
      want = pending_tx.pop_front();
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("tx_byte got %02h want %02h", got.tx_byte, want.tx_byte));
      if (got.frame_end !== want.frame_end)
        report($sformatf("frame_end got %b want %b (tx_byte %02h)",
                         got.frame_end, want.frame_end, want.tx_byte));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last got %b want %b (tx_byte %02h)",
                         got.run_last, want.run_last, want.tx_byte));
      if (got.framing_error !== want.framing_error)
        report($sformatf("framing_error got %b want %b (tx_byte %02h)",
                         got.framing_error, want.framing_error, want.tx_byte));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_func = FUNC_HEADER;
  logic [7:0]        in_pkt_type = 8'h00;
  logic [7:0]        in_pkt_length = 8'h00;
  logic [7:0]        in_data_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_tx_byte;
  logic              out_frame_end;
  logic              out_run_last;
  logic              out_framing_error;

  frame_tracker_t tracker = new();
  int           burst_left = 4;
  int           words_sent = 0;
  int           hold_requests = 0;
  int           cycle_count = 0;

  crc8_packet_framer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_pkt_type       (in_pkt_type),
    .in_pkt_length     (in_pkt_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_byte       (out_tx_byte),
    .out_frame_end     (out_frame_end),
    .out_run_last      (out_run_last),
    .out_framing_error (out_framing_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one word, hold it until taken, then maybe idle between bursts
  task automatic send_word(logic func, logic [7:0] ty, logic [7:0] len,
                           logic [7:0] data);
    int gap;
    in_valid      <= 1'b1;
    in_func       <= func;
    in_pkt_type   <= ty;
    in_pkt_length <= len;
    in_data_byte  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_word(func, ty, len, data);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_payload(logic [7:0] data);
    send_word(FUNC_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), data);
  endtask

  task automatic send_header(logic [7:0] ty, logic [7:0] len);
    send_word(FUNC_HEADER, ty, len, 8'($urandom_range(0, 255)));
  endtask

  // write the start code, then read it back in the next transfer
  task automatic write_start_code(logic [7:0] code);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= START_CODE_ADDR;
    pwdata  <= {24'h0, code};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.start_code = code;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== code)
      tracker.report($sformatf("start_code read %02h want %02h", prdata[7:0], code));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending_tx.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed packets; some cut short, some stray payload
  task automatic random_packets(int target);
    int         stop_at;
    int         r;
    int         n_data;
    logic [7:0] len;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_payload(pick_byte());
      end else begin
        if (r < 80)      len = 8'($urandom_range(0, 5));
        else if (r < 96) len = 8'($urandom_range(6, 20));
        else             len = 8'($urandom_range(21, 32));
        n_data = int'(len);
        if (len != 8'd0 && $urandom_range(0, 9) == 0)
          n_data = $urandom_range(0, int'(len) - 1);
        send_header(pick_byte(), len);
        repeat (n_data) send_payload(pick_byte());
      end
    end
  endtask

  // output side: check taken words, stall in shifting modes
  initial begin
    framed_word_t got;
    int           hold_served;
    int           hold_left;
    int           mode;
    int           tick;
    hold_served = 0;
    hold_left   = 0;
    mode        = 0;
    tick        = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.tx_byte       = out_tx_byte;
        got.frame_end     = out_frame_end;
        got.run_last      = out_run_last;
        got.framing_error = out_framing_error;
        tracker.check_tx(got);
      end
      tick++;
      if (tick % 97 == 0) mode = $urandom_range(0, 3);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (tick % 5 < 2);
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [7:0] codes [4];
    codes[0] = 8'h00;
    codes[1] = 8'hFF;
    codes[2] = 8'hAA;
    codes[3] = 8'($urandom_range(1, 254));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset start code
    send_payload(8'hFF);           // no packet open
    send_header(8'h00, 8'd0);      // empty packets
    send_header(8'hFF, 8'd0);
    send_header(8'h5A, 8'hFF);     // long packet, abandoned below
    send_payload(8'h00);
    send_payload(8'hFF);
    send_header(8'h81, 8'd2);
    send_payload(8'h7E);
    send_payload(8'h01);
    send_payload(8'h3C);           // stray after close
    send_header(8'h0F, 8'd1);
    send_payload(8'hA5);
    send_header(8'hC3, 8'd3);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h55);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      write_start_code(codes[p]);
      if (p == 1) hold_requests <= hold_requests + 1;
      random_packets(26);
      wait_drained();
    end

    if (tracker.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/crc8pf_pkg.sv
src/crc8pf_outq.sv
src/crc8_packet_framer_unit.sv
src/crc8pf_checker.sv
sim/crc8_packet_framer_unit_test.sv
